/* rtl/status_led_pattern_generator_assert.svh */
// ----------------------------------------------------------------------------
// status_led_pattern_generator_assert
// assertion macros shared by the status led pattern generator rtl
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH
`define STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SLPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SLPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SLPG_ASSERT_NOW(label, ante, cons, msg)
`define SLPG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/slpg_pkg.sv */
// ----------------------------------------------------------------------------
// slpg_pkg
// types, codes, constants and color helpers of the status led pattern generator
// ----------------------------------------------------------------------------
package slpg_pkg;

   // field widths
   localparam int MODE_W   = 8;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;
   localparam int COLOR_W  = 24;
   localparam int INDEX_W  = 8;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [PERIOD_W-1:0] period_type;
   typedef logic [COLOR_W-1:0]  color_type;
   typedef logic [INDEX_W-1:0]  index_type;

   // pattern codes
   localparam mode_type MODE_OFF         = 8'd0;
   localparam mode_type MODE_GREEN       = 8'd1;
   localparam mode_type MODE_SLOW_YELLOW = 8'd2;
   localparam mode_type MODE_FAST_RED    = 8'd3;
   localparam mode_type MODE_RAINBOW     = 8'd4;
   localparam mode_type MODE_RESET       = 8'd255;

   // register indexes
   localparam index_type REG_SLOW_BLINK   = 8'd0;
   localparam index_type REG_FAST_BLINK   = 8'd1;
   localparam index_type REG_RAINBOW_STEP = 8'd2;

   // register reset values
   localparam period_type SLOW_BLINK_RESET   = 16'd250;
   localparam period_type FAST_BLINK_RESET   = 16'd100;
   localparam period_type RAINBOW_STEP_RESET = 16'd20;

   // fixed colors
   localparam color_type COLOR_NONE = 24'h000000;
   localparam color_type LIT_GREEN  = 24'h002000;
   localparam color_type LIT_YELLOW = 24'h202000;
   localparam color_type LIT_RED    = 24'h200000;

   // wheel segment bounds
   localparam logic [7:0] WHEEL_SEG1 = 8'd85;
   localparam logic [7:0] WHEEL_SEG2 = 8'd170;
   localparam logic [7:0] WHEEL_MAX  = 8'd255;

   // wrapping elapsed test
   function automatic logic elapsed(time_type now, time_type stamp, period_type period);
      time_type diff;
      diff = now - stamp;
      return diff >= {{(TIME_W-PERIOD_W){1'b0}}, period};
   endfunction

   // three-segment color wheel, red 23:16 green 15:8 blue 7:0
   function automatic color_type color_wheel(logic [7:0] position);
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
      color_type  c;
      p = WHEEL_MAX - position;
      if (p < WHEEL_SEG1) begin
         t = 8'(p * 3);
         c = {WHEEL_MAX - t, 8'd0, t};
      end else if (p < WHEEL_SEG2) begin
         q = p - WHEEL_SEG1;
         t = 8'(q * 3);
         c = {8'd0, t, WHEEL_MAX - t};
      end else begin
         q = p - WHEEL_SEG2;
         t = 8'(q * 3);
         c = {t, WHEEL_MAX - t, 8'd0};
      end
      return c;
   endfunction

endpackage

/* rtl/status_led_pattern_generator.sv */
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// turns refresh requests (mode, millisecond time) into rgb status led colors
// ----------------------------------------------------------------------------
//  channel  ports                               direction  beat
//  req      req_valid req_ready req_mode ..     in         one refresh request
//  rsp      rsp_valid rsp_ready rsp_led_color   out        one color word
//  csr      csr_valid csr_ready csr_index ..    in         one register write
//
// one request per cycle sustained while rsp_ready stays high; a req beat passes
// an input register, then the timer and wheel logic into the result register,
// which drives rsp_valid and rsp_led_color.
// the pattern state updates as a request moves into the result register.
// a stalled rsp holds the result register; the input register still takes one
// more beat, then req_ready drops. csr_ready is always high.
// reset is synchronous and restores the register defaults and the state.
// ----------------------------------------------------------------------------
`include "status_led_pattern_generator_assert.svh"

module status_led_pattern_generator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  slpg_pkg::mode_type         req_mode,
   input  slpg_pkg::time_type         req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output slpg_pkg::color_type        rsp_led_color,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  slpg_pkg::index_type        csr_index,
   input  slpg_pkg::period_type       csr_data
);

   // configuration registers
   slpg_pkg::period_type slow_period_ff, fast_period_ff, step_period_ff;

   // input stage
   logic                 s1_valid_ff;
   slpg_pkg::mode_type   s1_mode_ff;
   slpg_pkg::time_type   s1_now_ff;

   // pattern state
   slpg_pkg::mode_type   prev_mode_ff, prev_mode_in;
   slpg_pkg::time_type   blink_stamp_ff, blink_stamp_in;
   logic                 blink_phase_ff, blink_phase_in;
   logic [7:0]           wheel_pos_ff, wheel_pos_in;
   slpg_pkg::time_type   rainbow_stamp_ff, rainbow_stamp_in;

   // result stage
   logic                 rsp_valid_ff;
   slpg_pkg::color_type  color_ff, color_in;

   logic                 advance;
   logic                 s1_move;
   logic                 s1_dark;
   logic                 mode_change;
   slpg_pkg::period_type blink_period;

   // handshakes
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_color = color_ff;

   // input stage moving into the result register, and its mode being unlit
   assign s1_move = advance && s1_valid_ff;
   assign s1_dark = (s1_mode_ff == slpg_pkg::MODE_OFF) ||
                    (s1_mode_ff > slpg_pkg::MODE_RAINBOW);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_period_ff <= slpg_pkg::SLOW_BLINK_RESET;
         fast_period_ff <= slpg_pkg::FAST_BLINK_RESET;
         step_period_ff <= slpg_pkg::RAINBOW_STEP_RESET;
      end else if (csr_valid) begin
         if (csr_index == slpg_pkg::REG_SLOW_BLINK)   slow_period_ff <= csr_data;
         if (csr_index == slpg_pkg::REG_FAST_BLINK)   fast_period_ff <= csr_data;
         if (csr_index == slpg_pkg::REG_RAINBOW_STEP) step_period_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_mode_ff <= req_mode;
         s1_now_ff  <= req_now_ms;
      end
   end

   // mode change restart, then the pattern of the requested mode
   always_comb begin
      mode_change  = s1_mode_ff != prev_mode_ff;
      prev_mode_in = s1_mode_ff;
      if (mode_change) begin
         blink_stamp_in   = s1_now_ff;
         rainbow_stamp_in = s1_now_ff;
         blink_phase_in   = 1'b1;
         wheel_pos_in     = 8'd0;
      end else begin
         blink_stamp_in   = blink_stamp_ff;
         rainbow_stamp_in = rainbow_stamp_ff;
         blink_phase_in   = blink_phase_ff;
         wheel_pos_in     = wheel_pos_ff;
      end
      blink_period = (s1_mode_ff == slpg_pkg::MODE_SLOW_YELLOW) ? slow_period_ff
                                                                : fast_period_ff;
      color_in = slpg_pkg::COLOR_NONE;
      unique case (s1_mode_ff)
         slpg_pkg::MODE_GREEN: begin
            color_in = slpg_pkg::LIT_GREEN;
         end
         slpg_pkg::MODE_SLOW_YELLOW, slpg_pkg::MODE_FAST_RED: begin
            if (slpg_pkg::elapsed(s1_now_ff, blink_stamp_in, blink_period)) begin
               blink_stamp_in = s1_now_ff;
               blink_phase_in = !blink_phase_in;
            end
            if (blink_phase_in) begin
               color_in = (s1_mode_ff == slpg_pkg::MODE_SLOW_YELLOW)
                          ? slpg_pkg::LIT_YELLOW : slpg_pkg::LIT_RED;
            end
         end
         slpg_pkg::MODE_RAINBOW: begin
            if (slpg_pkg::elapsed(s1_now_ff, rainbow_stamp_in, step_period_ff)) begin
               rainbow_stamp_in = s1_now_ff;
               wheel_pos_in     = wheel_pos_in + 8'd1;
            end
            color_in = slpg_pkg::color_wheel(wheel_pos_in);
         end
         default: begin
            color_in = slpg_pkg::COLOR_NONE;
         end
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         prev_mode_ff     <= slpg_pkg::MODE_RESET;
         blink_stamp_ff   <= '0;
         blink_phase_ff   <= 1'b0;
         wheel_pos_ff     <= 8'd0;
         rainbow_stamp_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            prev_mode_ff     <= prev_mode_in;
            blink_stamp_ff   <= blink_stamp_in;
            blink_phase_ff   <= blink_phase_in;
            wheel_pos_ff     <= wheel_pos_in;
            rainbow_stamp_ff <= rainbow_stamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         color_ff <= color_in;
      end
   end

   // checks
   `SLPG_ASSERT_NEXT(a_req_lands, req_valid && req_ready, s1_valid_ff, "req beat lost")
   `SLPG_ASSERT_NOW(a_backpressure, !advance && s1_valid_ff, !req_ready, "req taken while full")
   `SLPG_ASSERT_NEXT(a_prev_mode, s1_move, prev_mode_ff == $past(s1_mode_ff), "mode not tracked")
   `SLPG_ASSERT_NEXT(a_unknown_off, s1_move && s1_dark, rsp_led_color == '0, "unlit mode lit")

endmodule
